// ===== design/rdc_pkg.sv =====
// Shared widths and types for the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int VALUE_W    = 31;
  localparam int RADIX_W    = 9;
  localparam int DIGIT_W    = 8;
  localparam int MAX_DIGITS = 32;
  localparam int DEPTH_W    = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W     = $clog2(MAX_DIGITS);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(256);

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== design/rdc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rdc_divider.sv =====
// Iterative restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module rdc_divider
  import rdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(VALUE_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] quo_r, quo_nxt;
  logic [RADIX_W-1:0] rem_r, rem_nxt;
  logic [RADIX_W-1:0] dvs_r, dvs_nxt;
  logic [RADIX_W:0]   partial;
  logic               fits;

  // Bring down the next dividend bit and try a subtraction.
  assign partial = {rem_r, quo_r[VALUE_W-1]};
  assign fits    = partial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? RADIX_W'(partial - {1'b0, dvs_r}) : partial[RADIX_W-1:0];
      quo_nxt = {quo_r[VALUE_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  // The remainder is below the divisor, which never exceeds 256.
  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r[DIGIT_W-1:0];

endmodule

// ===== design/radix_digit_converter.sv =====
// Top level of the radix digit converter: control, digit stack and output register.
`timescale 1ns / 1ps

// The block takes one non-negative 31-bit word on the input channel and
// returns its digits in the configured radix on the output channel, one word
// per digit, most significant first, with last_digit high on the final one.
// A value of zero gives the single digit 0. The radix register is to be
// written through the cfg port only while the block is idle; the block itself
// does not enforce this. Values below two act as two and values above 256 act
// as 256. The value is divided repeatedly by the radix on a shared bit-serial
// divider, each remainder being pushed onto a digit stack held in a small RAM,
// and the stack is then popped to the output. Each digit takes one load of
// the divider and 31 quotient bits; the cycle in which a result is handed back
// also restarts the divider for the next digit. Digits are popped one at a
// time, each pop waiting for the RAM's registered read to land before the
// next is issued. A stalled receiver lengthens the pop phase. A new word is
// accepted once the stack has been emptied, even if the final digit is still
// waiting in the output register. Should more digits arise than the stack
// holds, the surplus high-order digits are dropped.

module radix_digit_converter
  import rdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DIGIT_W-1:0] out_digit,
  output logic               out_last_digit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RADIX_W-1:0] cfg_radix
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               pend_last_r, pend_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DIGIT_W-1:0] out_digit_r, out_digit_nxt;
  logic               out_last_r, out_last_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;

  logic [RADIX_W-1:0] eff_radix;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;
  logic [DEPTH_W-1:0] depth_dec;
  logic               out_free;

  // Clamp the radix into the range the divider and digit width support.
  always_comb begin
    if (radix_r < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix_r;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign depth_dec = depth_r - 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // A remainder is pushed whenever the divider finishes, unless the stack is full.
  assign ram_we    = (state_r == S_DIV) && div_rsp.done && (depth_r < DEPTH_W'(MAX_DIGITS));
  assign ram_waddr = depth_r[ADDR_W-1:0];
  // A pop is issued only when the output register will be free as the data lands.
  assign ram_re    = (state_r == S_POP) && (depth_r != '0) && !rd_pend_r && out_free;
  assign ram_raddr = depth_dec[ADDR_W-1:0];

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = in_value;
    div_req.divisor  = eff_radix;

    state_nxt     = state_r;
    depth_nxt     = depth_r;
    rd_pend_nxt   = ram_re;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;
    radix_nxt     = (cfg_valid && cfg_ready) ? cfg_radix : radix_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          div_req.start = 1'b1;
          depth_nxt     = '0;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (ram_we) begin
            depth_nxt = depth_r + 1'b1;
          end
          if (div_rsp.quotient == '0) begin
            state_nxt = S_POP;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
          end
        end
      end
      S_POP: begin
        if (ram_re) begin
          depth_nxt     = depth_dec;
          pend_last_nxt = (depth_dec == '0);
        end else if (depth_r == '0 && !rd_pend_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_digit_nxt = ram_rdata;
      out_last_nxt  = pend_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      radix_r     <= RADIX_RESET;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      radix_r     <= radix_nxt;
    end
    pend_last_r <= pend_last_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit      = out_digit_r;
  assign out_last_digit = out_last_r;

  rdc_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (div_rsp.remainder),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The stack never holds more digits than it has entries.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_DIGITS))
    else $error("digit stack depth exceeds its capacity");

  // A pending read always finds the output register empty.
  a_pend_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("stack read lands on an occupied output register");

  // The divider is never restarted while still working.
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A new word is only taken with an empty stack and no read in flight.
  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (depth_r == '0 && !rd_pend_r))
    else $error("word accepted while digits remain");

endmodule

// ===== bench/tb_radix_digit_converter.sv =====
// Self-checking testbench for the radix digit converter.
`timescale 1ns / 1ps

module tb_radix_digit_converter;
  import rdc_pkg::*;

  // Generous bound: even a run of nothing but 31-digit binary conversions with
  // a heavily stalled receiver stays well below this.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int REPORT_MAX  = 10;

  // One digit word as it should appear on the result channel.
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               is_last;
  } digit_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [DIGIT_W-1:0] out_digit;
  logic               out_last_digit;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_radix;

  // Digits still owed by the block, oldest first.
  digit_word_t        pending_digits[$];
  // Our own copy of the radix register, updated when a write is accepted.
  logic [RADIX_W-1:0] radix_setting;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_len;
  int mismatches;
  int cycle_count;

  radix_digit_converter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit      (out_digit),
    .out_last_digit (out_last_digit),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_radix      (cfg_radix)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost digit ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL radix_digit_converter");
      $finish;
    end
  end

  // Works out the digits of one value in the given radix and queues them,
  // most significant first. A radix below two acts as two and one above 256
  // acts as 256. Zero still gives one digit, and only the lowest MAX_DIGITS
  // digits survive should the stack overflow.
  function automatic void queue_radix_digits(input logic [VALUE_W-1:0] value,
                                             input logic [RADIX_W-1:0] radix);
    logic [RADIX_W-1:0] base;
    logic [VALUE_W-1:0] rest;
    logic [DIGIT_W-1:0] stack[$];
    digit_word_t        word;
    base = (radix < RADIX_MIN) ? RADIX_MIN : (radix > RADIX_MAX) ? RADIX_MAX : radix;
    rest = value;
    do begin
      if (stack.size() < MAX_DIGITS) begin
        stack.push_back(DIGIT_W'(rest % base));
      end
      rest = rest / base;
    end while (rest != 0);
    while (stack.size() != 0) begin
      word.digit   = stack.pop_back();
      word.is_last = (stack.size() == 0);
      pending_digits.push_back(word);
    end
  endfunction

  // Values spread over every digit count: whole range, short bit lengths,
  // small numbers and the two ends.
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned pick;
    int unsigned bits;
    logic [VALUE_W-1:0] mask;
    pick = $urandom_range(9);
    bits = $urandom_range(1, VALUE_W);
    mask = {VALUE_W{1'b1}} >> (VALUE_W - bits);
    case (pick)
      0, 1, 2: begin
        return VALUE_W'($urandom());
      end
      3, 4, 5, 6: begin
        return VALUE_W'($urandom()) & mask;
      end
      7: begin
        return VALUE_W'($urandom_range(0, 300));
      end
      8: begin
        return '0;
      end
      default: begin
        return {VALUE_W{1'b1}};
      end
    endcase
  endfunction

  // Receiver: stalls at random, or for a long stretch when a test asks for
  // one by loading hold_off_len.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len > 0) begin
        out_ready <= 1'b0;
        hold_off_len--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Checker: every digit word taken at a rising edge is matched against the
  // oldest one still owed.
  always @(posedge clk) begin
    digit_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_digits.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: unexpected digit word %0d last %0b", $realtime, out_digit,
                   out_last_digit);
        end
      end else begin
        want = pending_digits.pop_front();
        if (out_digit !== want.digit || out_last_digit !== want.is_last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: digit mismatch: expected %0d last %0b, got %0d last %0b",
                     $realtime, want.digit, want.is_last, out_digit, out_last_digit);
          end
        end
      end
    end
  end

  // Offers one value, after a random gap, and records its digits once the
  // block takes it. Returns just after the accepting edge with valid still
  // high, so the next call can follow on without a bubble.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_radix_digits(value, radix_setting);
  endtask

  // Drops valid and waits until every owed digit has come back, so the
  // block is idle and the radix may be changed.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] radix);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_radix <= radix;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    radix_setting = radix;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The reset radix of ten, before any write: zero, single digits, the first
  // two-digit value, a ten-digit value and the largest value.
  task automatic test_reset_radix();
    send_value('0);
    send_value(VALUE_W'(1));
    send_value(VALUE_W'(9));
    send_value(VALUE_W'(10));
    send_value(VALUE_W'(1_000_000_000));
    send_value({VALUE_W{1'b1}});
    wait_idle();
  endtask

  // Radix values at and beyond both ends: zero and one act as binary, which
  // gives the longest conversion, and anything above 256 saturates.
  task automatic test_radix_limits();
    write_radix(RADIX_W'(0));
    send_value({VALUE_W{1'b1}});
    send_value(VALUE_W'(1));
    wait_idle();
    write_radix(RADIX_W'(1));
    send_value(VALUE_W'(2));
    send_value('0);
    wait_idle();
    write_radix(RADIX_MIN);
    send_value(VALUE_W'(32'h5555_5555));
    wait_idle();
    write_radix(RADIX_W'(511));
    send_value({VALUE_W{1'b1}});
    send_value(VALUE_W'(255));
    send_value(VALUE_W'(256));
    wait_idle();
    write_radix(RADIX_MAX);
    send_value({VALUE_W{1'b1}});
    send_value('0);
    wait_idle();
    write_radix(RADIX_W'(257));
    send_value(VALUE_W'(65_536));
    wait_idle();
    write_radix(RADIX_W'(255));
    send_value(VALUE_W'(254));
    send_value({VALUE_W{1'b1}});
    wait_idle();
  endtask

  // Random values over four radix settings with the given idling on each
  // side of the block.
  task automatic test_random_values(input int send_pct, input int recv_pct);
    logic [RADIX_W-1:0] radix;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       radix = RADIX_W'($urandom_range(2, 16));
        1:       radix = RADIX_W'($urandom_range(17, 256));
        2:       radix = RADIX_W'($urandom_range(0, 511));
        default: radix = RADIX_W'($urandom_range(2, 36));
      endcase
      write_radix(radix);
      repeat (28) send_value(random_value());
      wait_idle();
    end
  endtask

  // The receiver holds off for a long stretch while values keep coming, so
  // the output register fills, digits wait in the stack and the input stalls.
  // Then the sender pauses until all has drained before sending again.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_radix(RADIX_W'(10));
    @(negedge clk);
    hold_off_len = 800;
    repeat (10) send_value(VALUE_W'($urandom()));
    wait_idle();
    recv_idle_pct = 30;
    repeat (6) send_value(random_value());
    wait_idle();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value      = '0;
    cfg_valid     = 1'b0;
    cfg_radix     = '0;
    radix_setting = RADIX_RESET;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_len  = 0;
    mismatches    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_radix();
    test_radix_limits();
    test_random_values(19, 67);
    test_random_values(67, 19);
    test_random_values(0, 0);
    test_output_stall();

    // Any stray digit still in flight would show up within this margin.
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_digits.size() == 0) begin
      $display("PASS radix_digit_converter");
    end else begin
      $display("FAIL radix_digit_converter");
    end
    $finish;
  end

endmodule
